/* design/signed_restoring_divider_defines.svh */
`ifndef SIGNED_RESTORING_DIVIDER_DEFINES_SVH
`define SIGNED_RESTORING_DIVIDER_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srd assertion failed");

// Next-cycle implication, checked while out of reset
`define SRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srd assertion failed");

`endif

/* design/srd_pkg.sv */
package srd_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      SRD_OK       = 2'd0,
      SRD_DIV_ZERO = 2'd1,
      SRD_OVERFLOW = 2'd2
   } srd_status_type;

   // travels alongside the datapath through every stage
   typedef struct packed {
      logic           neg;
      srd_status_type status;
   } srd_ctl_type;

endpackage

/* design/srd_if.sv */
interface srd_req_if #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
);
   import srd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] dividend;
   logic [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srd_rsp_if #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
);
   import srd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] quotient;
   logic [1:0]            status;

   modport source (output valid, output quotient, output status, input ready);
   modport sink   (input valid, input quotient, input status, output ready);
endinterface

/* design/srd_prep.sv */
module srd_prep #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [DATA_WIDTH-1:0] num,
   output logic [DATA_WIDTH-1:0] den,
   output srd_pkg::srd_ctl_type  ctl
);
   import srd_pkg::*;

   localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   srd_ctl_type           ctl_ff, ctl_in;
   logic                  load;
   logic                  n_neg, d_neg;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      n_neg  = dividend[DATA_WIDTH-1];
      d_neg  = divisor[DATA_WIDTH-1];
      // most negative value maps to 2^(W-1), which fits unsigned
      num_in = n_neg ? (~dividend + 1'b1) : dividend;
      den_in = d_neg ? (~divisor + 1'b1) : divisor;
      ctl_in.neg = n_neg ^ d_neg;
      priority if (divisor == '0) begin
         ctl_in.status = SRD_DIV_ZERO;
      end else if (dividend == MinNeg && divisor == '1) begin
         ctl_in.status = SRD_OVERFLOW;
      end else begin
         ctl_in.status = SRD_OK;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= num_in;
         den_ff <= den_in;
         ctl_ff <= ctl_in;
      end
   end

   assign dn_valid = valid_ff;
   assign num      = num_ff;
   assign den      = den_ff;
   assign ctl      = ctl_ff;

endmodule

/* design/srd_cell.sv */
module srd_cell #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [DATA_WIDTH-1:0] up_rem,
   input  logic [DATA_WIDTH-1:0] up_num,
   input  logic [DATA_WIDTH-1:0] up_den,
   input  logic [DATA_WIDTH-1:0] up_quo,
   input  srd_pkg::srd_ctl_type  up_ctl,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [DATA_WIDTH-1:0] dn_rem,
   output logic [DATA_WIDTH-1:0] dn_num,
   output logic [DATA_WIDTH-1:0] dn_den,
   output logic [DATA_WIDTH-1:0] dn_quo,
   output srd_pkg::srd_ctl_type  dn_ctl
);
   import srd_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   srd_ctl_type           ctl_ff;
   logic                  load;
   logic [DATA_WIDTH-1:0] rem_sh;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      // partial remainder stays below the divisor, so its top bit is spare
      rem_sh = {up_rem[DATA_WIDTH-2:0], up_num[DATA_WIDTH-1]};
      diff   = {1'b0, rem_sh} - {1'b0, up_den};
      fits   = !diff[DATA_WIDTH];
      rem_in = fits ? diff[DATA_WIDTH-1:0] : rem_sh;
      num_in = {up_num[DATA_WIDTH-2:0], 1'b0};
      quo_in = {up_quo[DATA_WIDTH-2:0], fits};
      if (load) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= up_den;
         quo_ff <= quo_in;
         ctl_ff <= up_ctl;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
   assign dn_quo   = quo_ff;
   assign dn_ctl   = ctl_ff;

endmodule

/* design/srd_post.sv */
module srd_post #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [DATA_WIDTH-1:0] up_quo,
   input  srd_pkg::srd_ctl_type  up_ctl,
   srd_rsp_if.source             rsp
);
   import srd_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   srd_status_type        status_ff;
   logic                  load;

   assign up_ready = !valid_ff || rsp.ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      if (up_ctl.status != SRD_OK) begin
         quo_in = '0;
      end else if (up_ctl.neg) begin
         quo_in = ~up_quo + 1'b1;
      end else begin
         quo_in = up_quo;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff    <= quo_in;
         status_ff <= up_ctl.status;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.status   = status_ff;

endmodule

/* design/signed_restoring_divider.sv */
// Signed divider, quotient truncated toward zero. One request may enter every
// clock; its response passes through one input stage that takes magnitudes
// and flags the special cases, one restoring-division cell per quotient bit
// and one output register that fixes the sign. Back-pressure on rsp stalls
// only the stages that hold data, so empty slots still take requests. A zero
// divisor returns status 1, most-negative by minus one returns status 2; both
// with quotient zero. No remainder is returned.
`include "signed_restoring_divider_defines.svh"

module signed_restoring_divider #(
   parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srd_req_if.sink   req,
   srd_rsp_if.source rsp
);
   import srd_pkg::*;

   localparam int Stages  = DATA_WIDTH + 2;
   localparam int OccBits = $clog2(Stages + 1);

   logic                  c_valid [0:DATA_WIDTH];
   logic                  c_ready [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] c_rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] c_num   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] c_den   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] c_quo   [0:DATA_WIDTH];
   srd_ctl_type           c_ctl   [0:DATA_WIDTH];

   srd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req.valid),
      .up_ready (req.ready),
      .dividend (req.dividend),
      .divisor  (req.divisor),
      .dn_valid (c_valid[0]),
      .dn_ready (c_ready[0]),
      .num      (c_num[0]),
      .den      (c_den[0]),
      .ctl      (c_ctl[0])
   );

   assign c_rem[0] = '0;
   assign c_quo[0] = '0;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      srd_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c_valid[i]),
         .up_ready (c_ready[i]),
         .up_rem   (c_rem[i]),
         .up_num   (c_num[i]),
         .up_den   (c_den[i]),
         .up_quo   (c_quo[i]),
         .up_ctl   (c_ctl[i]),
         .dn_valid (c_valid[i+1]),
         .dn_ready (c_ready[i+1]),
         .dn_rem   (c_rem[i+1]),
         .dn_num   (c_num[i+1]),
         .dn_den   (c_den[i+1]),
         .dn_quo   (c_quo[i+1]),
         .dn_ctl   (c_ctl[i+1])
      );
   end

   srd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
      .clock    (clock),
      .reset    (reset),
      .up_valid (c_valid[DATA_WIDTH]),
      .up_ready (c_ready[DATA_WIDTH]),
      .up_quo   (c_quo[DATA_WIDTH]),
      .up_ctl   (c_ctl[DATA_WIDTH]),
      .rsp      (rsp)
   );

   // requests in flight, for checking only
   logic [OccBits-1:0] occ_ff, occ_in;
   logic               req_fire, rsp_fire;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_fire && !rsp_fire) begin
         occ_in = occ_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `SRD_ASSERT_IMPL(a_err_zero_quo, clock, reset,
      rsp.valid && rsp.status != SRD_OK, rsp.quotient == '0)
   `SRD_ASSERT_IMPL(a_drain_takes_req, clock, reset, rsp.ready, req.ready)
   `SRD_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= OccBits'(Stages))
   `SRD_ASSERT_IMPL(a_empty_no_rsp, clock, reset, occ_ff == '0, !rsp.valid)
   `SRD_ASSERT_IMPL(a_full_blocks, clock, reset,
      occ_ff == OccBits'(Stages) && !rsp.ready, !req.ready)
   `SRD_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.quotient))

endmodule

/* bench/signed_restoring_divider_tb.sv */
module signed_restoring_divider_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srd_pkg::*;

   localparam int W            = DATA_WIDTH_DEF;
   localparam int RESET_CYCLES = 5;
   localparam int GAP_PCT      = 13;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 60;
   localparam int N_DIRECTED   = 24;

   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINUS_1  = {W{1'b1}};

   typedef struct packed {
      logic [W-1:0]   quotient;
      srd_status_type status;
   } div_result_type;

   typedef struct packed {
      logic [W-1:0]   dividend;
      logic [W-1:0]   divisor;
      logic           typed;
      logic [W-1:0]   quotient;
      srd_status_type status;
   } div_case_type;

   logic clock;
   logic reset;

   srd_req_if #(.DATA_WIDTH(W)) req_ch ();
   srd_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

   signed_restoring_divider #(.DATA_WIDTH(W)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   div_result_type pending_quotients[$];
   int             errors = 0;
   bit             src_gaps_on  = 1'b1;
   bit             sink_gaps_on = 1'b1;
   bit             hold_request = 1'b0;

   // typed rows: error codes and the extremes; the rest go to the predictor
   div_case_type directed_cases [N_DIRECTED] = '{
      '{32'd7,      32'd0,      1'b1, 32'd0,          SRD_DIV_ZERO},
      '{32'd0,      32'd0,      1'b1, 32'd0,          SRD_DIV_ZERO},
      '{MOST_NEG,   32'd0,      1'b1, 32'd0,          SRD_DIV_ZERO},
      '{MOST_NEG,   MINUS_1,    1'b1, 32'd0,          SRD_OVERFLOW},
      '{MOST_NEG,   32'd1,      1'b1, MOST_NEG,       SRD_OK},
      '{MOST_NEG,   MOST_NEG,   1'b1, 32'd1,          SRD_OK},
      '{MOST_POS,   MOST_NEG,   1'b1, 32'd0,          SRD_OK},
      '{32'd5,      MOST_NEG,   1'b1, 32'd0,          SRD_OK},
      '{MOST_POS,   32'd1,      1'b1, MOST_POS,       SRD_OK},
      '{MOST_POS,   MINUS_1,    1'b1, 32'h8000_0001,  SRD_OK},
      '{MOST_NEG,   32'd2,      1'b1, 32'hC000_0000,  SRD_OK},
      '{MOST_NEG,   32'hFFFF_FFFE, 1'b1, 32'h4000_0000, SRD_OK},
      '{MOST_NEG,   MOST_POS,   1'b1, MINUS_1,        SRD_OK},
      '{MOST_POS,   MOST_POS,   1'b1, 32'd1,          SRD_OK},
      '{MINUS_1,    MINUS_1,    1'b1, 32'd1,          SRD_OK},
      '{32'd0,      32'd5,      1'b1, 32'd0,          SRD_OK},
      '{32'd7,      32'd2,      1'b0, 32'd0,          SRD_OK},
      '{32'hFFFF_FFF9, 32'd2,   1'b0, 32'd0,          SRD_OK},
      '{32'd7,      32'hFFFF_FFFE, 1'b0, 32'd0,       SRD_OK},
      '{32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 32'd0,    SRD_OK},
      '{32'd100,    32'd7,      1'b0, 32'd0,          SRD_OK},
      '{32'hFFFF_0000, 32'd3,   1'b0, 32'd0,          SRD_OK},
      '{32'd12345678, 32'hFFFF_FFF7, 1'b0, 32'd0,     SRD_OK},
      '{MINUS_1,    MOST_POS,   1'b0, 32'd0,          SRD_OK}
   };

   function automatic div_result_type divide_truncating(logic [W-1:0] num, logic [W-1:0] den);
      div_result_type res;
      logic [W-1:0]   mag_n;
      logic [W-1:0]   mag_d;
      logic [W:0]     rem;
      logic [W-1:0]   quo;
      res.quotient = '0;
      res.status   = SRD_OK;
      if (den == '0) begin
         res.status = SRD_DIV_ZERO;
         return res;
      end
      if (num == MOST_NEG && den == MINUS_1) begin
         res.status = SRD_OVERFLOW;
         return res;
      end
      // most negative negates to itself, which is the right magnitude unsigned
      mag_n = num[W-1] ? -num : num;
      mag_d = den[W-1] ? -den : den;
      rem   = '0;
      quo   = '0;
      for (int i = W - 1; i >= 0; i--) begin
         rem = {rem[W-1:0], mag_n[i]};
         if (rem >= {1'b0, mag_d}) begin
            rem    = rem - {1'b0, mag_d};
            quo[i] = 1'b1;
         end
      end
      res.quotient = (num[W-1] != den[W-1]) ? -quo : quo;
      return res;
   endfunction

   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(7))
         3: v = $urandom >> $urandom_range(W - 1);
         4: v = -($urandom >> $urandom_range(W - 1));
         5: v = $urandom_range(16) - 8;
         6: begin
            case ($urandom_range(4))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = MINUS_1;
               3: v = '0;
               default: v = 1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_request(logic [W-1:0] num, logic [W-1:0] den, div_result_type want);
      if (src_gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < GAP_PCT);
      end
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= num;
      req_ch.divisor  <= den;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_quotients.push_back(want);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("signed_restoring_divider: mismatch");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= !(sink_gaps_on && $urandom_range(99) < GAP_PCT);
         end
      end
   end

   always @(posedge clock) begin
      div_result_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_quotients.size() == 0) begin
            errors++;
            $display("%0t: unexpected response quotient %h status %0d",
                     $time, rsp_ch.quotient, rsp_ch.status);
         end else begin
            want = pending_quotients.pop_front();
            if (rsp_ch.quotient !== want.quotient) begin
               errors++;
               $display("%0t: quotient expected %h actual %h",
                        $time, want.quotient, rsp_ch.quotient);
            end
            if (rsp_ch.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_ch.status);
            end
         end
      end
   end

   initial begin
      logic [W-1:0]   num;
      logic [W-1:0]   den;
      div_result_type want;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.dividend <= '0;
      req_ch.divisor  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         if (directed_cases[i].typed) begin
            want.quotient = directed_cases[i].quotient;
            want.status   = directed_cases[i].status;
         end else begin
            want = divide_truncating(directed_cases[i].dividend, directed_cases[i].divisor);
         end
         send_request(directed_cases[i].dividend, directed_cases[i].divisor, want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long run with no gaps on either side
         if (n == 300) begin
            src_gaps_on  = 1'b0;
            sink_gaps_on = 1'b0;
         end
         if (n == 550) begin
            src_gaps_on  = 1'b1;
            sink_gaps_on = 1'b1;
         end
         // receiver holds off while requests keep coming, so the pipe backs up
         if (n == 800) begin
            src_gaps_on  = 1'b0;
            hold_request = 1'b1;
         end
         if (n == 900)
            src_gaps_on = 1'b1;
         // sender pauses until the pipe has drained
         if (n == 1200) begin
            req_ch.valid <= 1'b0;
            wait (pending_quotients.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(49) == 0) begin
            num = MOST_NEG;
            den = MINUS_1;
         end else begin
            num = pick_operand();
            den = pick_operand();
         end
         send_request(num, den, divide_truncating(num, den));
      end
      req_ch.valid <= 1'b0;

      wait (pending_quotients.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("signed_restoring_divider: match");
      else
         $display("signed_restoring_divider: mismatch");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/srd_pkg.sv
design/srd_if.sv
design/srd_prep.sv
design/srd_cell.sv
design/srd_post.sv
design/signed_restoring_divider.sv
bench/signed_restoring_divider_tb.sv
